// File: sv/lcdseq_pkg.sv
// ============================================================================
// lcdseq_pkg
// Shared types, codes and pin-state tables for the character LCD sequencer.
// ============================================================================
package lcdseq_pkg;

    // Request operation codes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Job kinds carried through the queue
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    localparam int HOLD_W = 15;
    localparam int NIB_W  = 4;

    // Step counts per job
    localparam int INIT_STEPS = 21;
    localparam int BYTE_STEPS = 4;
    localparam int STEP_W     = $clog2(INIT_STEPS);
    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_STEPS - 1);
    localparam logic [1:0]        BYTE_LAST = 2'(BYTE_STEPS - 1);

    // Hold times in microseconds
    localparam logic [HOLD_W-1:0] HOLD_PULSE    = 15'd1;
    localparam logic [HOLD_W-1:0] HOLD_SHORT    = 15'd50;
    localparam logic [HOLD_W-1:0] HOLD_LONG     = 15'd2050;
    localparam logic [HOLD_W-1:0] HOLD_INIT_MID = 15'd200;
    localparam logic [HOLD_W-1:0] HOLD_INIT_1ST = 15'd5050;
    localparam logic [HOLD_W-1:0] HOLD_POWERUP  = 15'd20000;
    localparam logic [HOLD_W-1:0] HOLD_FINAL    = 15'd4050;

    // Front to back queue
    localparam int QDEPTH  = 2;
    localparam int QADDR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       rs;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One pin state of the power-up sequence
    typedef struct packed {
        logic              set_data;
        logic              clr_rs;
        logic [NIB_W-1:0]  nibble;
        logic              en;
        logic [HOLD_W-1:0] hold;
    } init_step_t;

    function automatic init_step_t init_step(input logic [STEP_W-1:0] idx);
        init_step_t s;
        s = '0;
        unique case (idx)
            5'd0:  s = '{1'b0, 1'b0, 4'h0, 1'b0, HOLD_POWERUP};
            5'd1:  s = '{1'b1, 1'b0, 4'h3, 1'b1, HOLD_PULSE};
            5'd2:  s = '{1'b1, 1'b0, 4'h3, 1'b0, HOLD_INIT_1ST};
            5'd3:  s = '{1'b1, 1'b0, 4'h3, 1'b1, HOLD_PULSE};
            5'd4:  s = '{1'b1, 1'b0, 4'h3, 1'b0, HOLD_INIT_MID};
            5'd5:  s = '{1'b1, 1'b0, 4'h3, 1'b1, HOLD_PULSE};
            5'd6:  s = '{1'b1, 1'b0, 4'h3, 1'b0, HOLD_INIT_MID};
            5'd7:  s = '{1'b1, 1'b0, 4'h2, 1'b1, HOLD_PULSE};
            5'd8:  s = '{1'b1, 1'b0, 4'h2, 1'b0, HOLD_LONG};
            5'd9:  s = '{1'b1, 1'b1, 4'h2, 1'b1, HOLD_PULSE};
            5'd10: s = '{1'b1, 1'b1, 4'h2, 1'b0, HOLD_SHORT};
            5'd11: s = '{1'b1, 1'b1, 4'h8, 1'b1, HOLD_PULSE};
            5'd12: s = '{1'b1, 1'b1, 4'h8, 1'b0, HOLD_LONG};
            5'd13: s = '{1'b1, 1'b1, 4'h0, 1'b1, HOLD_PULSE};
            5'd14: s = '{1'b1, 1'b1, 4'h0, 1'b0, HOLD_SHORT};
            5'd15: s = '{1'b1, 1'b1, 4'hC, 1'b1, HOLD_PULSE};
            5'd16: s = '{1'b1, 1'b1, 4'hC, 1'b0, HOLD_LONG};
            5'd17: s = '{1'b1, 1'b1, 4'h0, 1'b1, HOLD_PULSE};
            5'd18: s = '{1'b1, 1'b1, 4'h0, 1'b0, HOLD_SHORT};
            5'd19: s = '{1'b1, 1'b1, 4'h1, 1'b1, HOLD_PULSE};
            5'd20: s = '{1'b1, 1'b1, 4'h1, 1'b0, HOLD_FINAL};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// File: sv/lcdseq_front.sv
// ============================================================================
// lcdseq_front
// Accepts request beats and turns them into queue jobs.
// ============================================================================
module lcdseq_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_byte_value,
    input  logic               s_register_select,
    input  logic [5:0]         s_column,
    input  logic               s_row,
    input  lcdseq_pkg::q_status_t q_status,
    output logic               push,
    output lcdseq_pkg::item_t  push_item
);
    import lcdseq_pkg::*;

    assign s_ready = !q_status.full;

    always_comb begin
        push_item = '0;
        push      = 1'b0;
        unique case (s_operation)
            OP_INIT: begin
                push_item.kind = KIND_INIT;
                push           = s_valid && s_ready;
            end
            OP_BYTE: begin
                push_item.kind  = KIND_BYTE;
                push_item.value = s_byte_value;
                push_item.rs    = s_register_select;
                push            = s_valid && s_ready;
            end
            OP_CURSOR: begin
                // 0x80 + column on row 0, 0xC0 + column on row 1
                push_item.kind  = KIND_BYTE;
                push_item.value = {1'b1, s_row, s_column};
                push_item.rs    = 1'b0;
                push            = s_valid && s_ready;
            end
            OP_NONE: begin
                // drop the beat
                push = 1'b0;
            end
            default: push = 1'b0;
        endcase
    end

endmodule

// File: sv/lcdseq_queue.sv
// ============================================================================
// lcdseq_queue
// Short job queue between the front and the back.
// ============================================================================
module lcdseq_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  lcdseq_pkg::item_t      push_item,
    input  logic                   pop,
    output lcdseq_pkg::item_t      head_item,
    output lcdseq_pkg::q_status_t  status
);
    import lcdseq_pkg::*;

    item_t              slot_reg [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [QADDR_W-1:0] ptr_inc(input logic [QADDR_W-1:0] p);
        return (p == QADDR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head_item    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/lcdseq_back.sv
// ============================================================================
// lcdseq_back
// Steps through the pin states of the head job into the output register.
// ============================================================================
module lcdseq_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lcdseq_pkg::item_t      head_item,
    input  lcdseq_pkg::q_status_t  q_status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_rs_pin,
    output logic                   m_enable_pin,
    output logic [3:0]             m_data_nibble,
    output logic [14:0]            m_hold_us,
    output logic                   m_last_step
);
    import lcdseq_pkg::*;

    logic              rs_level_reg, rs_level_next;
    logic [NIB_W-1:0]  data_level_reg, data_level_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_rs_reg, out_en_reg, out_last_reg;
    logic [NIB_W-1:0]  out_data_reg;
    logic [HOLD_W-1:0] out_hold_reg;

    init_step_t        ist;
    logic [1:0]        bstep;
    logic              cur_rs, cur_en, cur_last;
    logic [NIB_W-1:0]  cur_data;
    logic [HOLD_W-1:0] cur_hold;
    logic              emit;

    assign ist   = init_step(step_reg);
    assign bstep = step_reg[1:0];

    always_comb begin
        if (head_item.kind == KIND_INIT) begin
            cur_rs   = ist.clr_rs ? 1'b0 : rs_level_reg;
            cur_data = ist.set_data ? ist.nibble : data_level_reg;
            cur_en   = ist.en;
            cur_hold = ist.hold;
            cur_last = (step_reg == INIT_LAST);
        end else begin
            cur_rs   = head_item.rs;
            cur_data = bstep[1] ? head_item.value[3:0] : head_item.value[7:4];
            cur_en   = !bstep[0];
            priority if (bstep == 2'd1) begin
                cur_hold = HOLD_SHORT;
            end else if (bstep == BYTE_LAST) begin
                cur_hold = HOLD_LONG;
            end else begin
                cur_hold = HOLD_PULSE;
            end
            cur_last = (bstep == BYTE_LAST);
        end
    end

    assign emit = !q_status.empty && (!out_valid_reg || m_ready);
    assign pop  = emit && cur_last;

    always_comb begin
        rs_level_next   = emit ? cur_rs : rs_level_reg;
        data_level_next = emit ? cur_data : data_level_reg;
        step_next       = step_reg;
        if (emit) begin
            step_next = cur_last ? '0 : step_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_level_reg   <= 1'b0;
            data_level_reg <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            rs_level_reg   <= rs_level_next;
            data_level_reg <= data_level_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_rs_reg   <= cur_rs;
            out_en_reg   <= cur_en;
            out_data_reg <= cur_data;
            out_hold_reg <= cur_hold;
            out_last_reg <= cur_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_rs_pin      = out_rs_reg;
    assign m_enable_pin  = out_en_reg;
    assign m_data_nibble = out_data_reg;
    assign m_hold_us     = out_hold_reg;
    assign m_last_step   = out_last_reg;

endmodule

// File: sv/char_lcd_nibble_write_sequencer_unit.sv
// ============================================================================
// char_lcd_nibble_write_sequencer_unit
// Character LCD 4-bit bus sequencer: requests in, timed pin states out.
// ============================================================================
//
//  Channel | Direction | Beat carries
//  --------+-----------+-----------------------------------------------------
//  s_*     | in        | operation, byte_value, register_select, column, row
//  m_*     | out       | rs_pin, enable_pin, data_nibble, hold_us, last_step
//
//  One pin state leaves per cycle while m_ready is high and a job is
//  queued: a byte send, a cursor set or an initialisation is walked
//  through its pin states by the back-end step counter feeding the single
//  output register. An unused operation code is taken and produces nothing.
//  The front takes a request whenever the 2-entry job queue has room, so a
//  stall on m_ready backs up into the queue before it reaches s_ready.
//  aresetn (synchronous, active low) clears the queue, the step counter,
//  the output valid and the kept RS and data levels.
//
module char_lcd_nibble_write_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_byte_value,
    input  logic        s_register_select,
    input  logic [5:0]  s_column,
    input  logic        s_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rs_pin,
    output logic        m_enable_pin,
    output logic [3:0]  m_data_nibble,
    output logic [14:0] m_hold_us,
    output logic        m_last_step
);
    import lcdseq_pkg::*;

    // Front to queue
    logic      push;
    item_t     push_item;
    // Queue to back
    logic      pop;
    item_t     head_item;
    q_status_t q_status;

    // Classify the request and push a job
    lcdseq_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_byte_value      (s_byte_value),
        .s_register_select (s_register_select),
        .s_column          (s_column),
        .s_row             (s_row),
        .q_status          (q_status),
        .push              (push),
        .push_item         (push_item)
    );

    // Hold pending jobs so each side stalls on its own
    lcdseq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    // Walk the pin states of the head job
    lcdseq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_item     (head_item),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rs_pin      (m_rs_pin),
        .m_enable_pin  (m_enable_pin),
        .m_data_nibble (m_data_nibble),
        .m_hold_us     (m_hold_us),
        .m_last_step   (m_last_step)
    );

    // Never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    // Never retire a job from an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("job retired from empty queue");

    // Enable strobes always last one microsecond
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_enable_pin) |-> (m_hold_us == HOLD_PULSE))
        else $error("enable strobe with wrong hold");

    // Closing state of an initialisation is a command with nibble 0x1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hold_us == HOLD_FINAL) |->
            (m_last_step && !m_rs_pin && m_data_nibble == 4'h1))
        else $error("bad closing state of initialisation");

endmodule

// File: dv/char_lcd_pin_checker.sv
// ============================================================================
// char_lcd_pin_checker
// Watches both channels of the LCD sequencer, predicts the pin states that
// each accepted request must produce, and compares every result beat with
// the oldest one still due.
// ============================================================================
module char_lcd_pin_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [7:0]                    s_byte_value,
    input  logic                          s_register_select,
    input  logic [5:0]                    s_column,
    input  logic                          s_row,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_rs_pin,
    input  logic                          m_enable_pin,
    input  logic [lcdseq_pkg::NIB_W-1:0]  m_data_nibble,
    input  logic [lcdseq_pkg::HOLD_W-1:0] m_hold_us,
    input  logic                          m_last_step,
    output int                            mismatch_count,
    output int                            pins_pending
);
    import lcdseq_pkg::*;

    // Hold times and settle extensions in microseconds
    localparam logic [HOLD_W-1:0] T_PULSE         = 15'd1;
    localparam logic [HOLD_W-1:0] T_LOW           = 15'd50;
    localparam logic [HOLD_W-1:0] T_POWERUP       = 15'd20000;
    localparam logic [HOLD_W-1:0] T_FINAL         = 15'd4050;
    localparam logic [HOLD_W-1:0] SETTLE_NONE     = 15'd0;
    localparam logic [HOLD_W-1:0] SETTLE_WAKE_1ST = 15'd5000;
    localparam logic [HOLD_W-1:0] SETTLE_WAKE     = 15'd150;
    localparam logic [HOLD_W-1:0] SETTLE_LONG     = 15'd2000;

    // Power-up nibbles and commands, cursor address bases
    localparam logic [NIB_W-1:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [NIB_W-1:0] FOUR_BIT_NIBBLE  = 4'h2;
    localparam logic [7:0]       CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0]       CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0]       CMD_CLEAR        = 8'h01;
    localparam logic [7:0]       ROW0_BASE        = 8'h80;
    localparam logic [7:0]       ROW1_BASE        = 8'hC0;

    typedef struct packed {
        logic              rs;
        logic              en;
        logic [NIB_W-1:0]  nib;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } pin_state_t;

    pin_state_t       pins_due[$];
    logic             lcd_rs_level   = 1'b0;
    logic [NIB_W-1:0] lcd_data_level = '0;
    int               fail_cnt       = 0;

    task automatic put_pin(input logic en, input logic [HOLD_W-1:0] hold);
        pins_due.push_back(pin_state_t'{lcd_rs_level, en, lcd_data_level, hold, 1'b0});
    endtask

    task automatic pulse_nibble(input logic [NIB_W-1:0] nib,
                                input logic [HOLD_W-1:0] settle);
        lcd_data_level = nib;
        put_pin(1'b1, T_PULSE);
        put_pin(1'b0, T_LOW + settle);
    endtask

    task automatic write_byte(input logic [7:0] value, input logic mode);
        lcd_rs_level = mode;
        pulse_nibble(value[7:4], SETTLE_NONE);
        pulse_nibble(value[3:0], SETTLE_LONG);
    endtask

    task automatic predict_request(input logic [1:0] op, input logic [7:0] value,
                                   input logic mode, input logic [5:0] col,
                                   input logic row);
        pin_state_t tail;
        logic [7:0] addr;
        case (op)
            OP_INIT: begin
                put_pin(1'b0, T_POWERUP);
                pulse_nibble(WAKE_NIBBLE, SETTLE_WAKE_1ST);
                pulse_nibble(WAKE_NIBBLE, SETTLE_WAKE);
                pulse_nibble(WAKE_NIBBLE, SETTLE_WAKE);
                pulse_nibble(FOUR_BIT_NIBBLE, SETTLE_LONG);
                write_byte(CMD_FUNCTION_SET, 1'b0);
                write_byte(CMD_DISPLAY_ON, 1'b0);
                write_byte(CMD_CLEAR, 1'b0);
            end
            OP_BYTE: begin
                write_byte(value, mode);
            end
            OP_CURSOR: begin
                addr = (row ? ROW1_BASE : ROW0_BASE) + {2'b00, col};
                write_byte(addr, 1'b0);
            end
            default: return;
        endcase
        tail = pins_due.pop_back();
        if (op == OP_INIT) tail.hold = T_FINAL;
        tail.last = 1'b1;
        pins_due.push_back(tail);
    endtask

    always @(posedge aclk) begin : watch_beats
        pin_state_t want;
        logic       bad;
        if (!aresetn) begin
            pins_due.delete();
            lcd_rs_level   = 1'b0;
            lcd_data_level = '0;
        end else begin
            if (s_valid && s_ready)
                predict_request(s_operation, s_byte_value, s_register_select,
                                s_column, s_row);
            if (m_valid && m_ready) begin
                if (pins_due.size() == 0) begin
                    $error("unexpected pin state: rs %0d en %0d data %h hold %0d last %0d",
                           m_rs_pin, m_enable_pin, m_data_nibble, m_hold_us, m_last_step);
                    fail_cnt++;
                end else begin
                    want = pins_due.pop_front();
                    bad  = 1'b0;
                    if (m_rs_pin !== want.rs) begin
                        $error("rs_pin: expected %0d, actual %0d", want.rs, m_rs_pin);
                        bad = 1'b1;
                    end
                    if (m_enable_pin !== want.en) begin
                        $error("enable_pin: expected %0d, actual %0d", want.en, m_enable_pin);
                        bad = 1'b1;
                    end
                    if (m_data_nibble !== want.nib) begin
                        $error("data_nibble: expected %h, actual %h", want.nib, m_data_nibble);
                        bad = 1'b1;
                    end
                    if (m_hold_us !== want.hold) begin
                        $error("hold_us: expected %0d, actual %0d", want.hold, m_hold_us);
                        bad = 1'b1;
                    end
                    if (m_last_step !== want.last) begin
                        $error("last_step: expected %0d, actual %0d", want.last, m_last_step);
                        bad = 1'b1;
                    end
                    if (bad) fail_cnt++;
                end
            end
        end
        mismatch_count <= fail_cnt;
        pins_pending   <= pins_due.size();
    end

endmodule

// File: dv/char_lcd_nibble_write_sequencer_unit_tb.sv
// ============================================================================
// char_lcd_nibble_write_sequencer_unit_tb
// Drives display requests into the LCD sequencer under varying idle and
// stall patterns; a checker beside the block predicts and compares every
// pin-state beat, and this top gives the verdict.
// ============================================================================
module char_lcd_nibble_write_sequencer_unit_tb;
    import lcdseq_pkg::*;

    // Traffic phases: who idles, and how often (percent of cycles)
    typedef enum logic [1:0] {
        PH_SLOW_SINK   = 2'd0,   // sender 23, receiver 58
        PH_SLOW_SOURCE = 2'd1,   // sender 58, receiver 23
        PH_FULL_RATE   = 2'd2    // nobody idles, apart from one long stall
    } traffic_phase_t;

    localparam int RANDOM_REQUESTS = 360;
    localparam int REQUESTS_PER_PH = 120;
    localparam int LONG_STALL      = 300;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES    = 40;    // covers stray beats after the last due state
    localparam int IDLE_LIMIT      = 3000;  // cycles with no beat at all

    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation       = OP_NONE;
    logic [7:0]        s_byte_value      = '0;
    logic              s_register_select = 1'b0;
    logic [5:0]        s_column          = '0;
    logic              s_row             = 1'b0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic              m_rs_pin;
    logic              m_enable_pin;
    logic [NIB_W-1:0]  m_data_nibble;
    logic [HOLD_W-1:0] m_hold_us;
    logic              m_last_step;

    traffic_phase_t phase = PH_SLOW_SINK;
    int             mismatch_count;
    int             pins_pending;

    always #5 aclk = ~aclk;

    char_lcd_nibble_write_sequencer_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_byte_value      (s_byte_value),
        .s_register_select (s_register_select),
        .s_column          (s_column),
        .s_row             (s_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rs_pin          (m_rs_pin),
        .m_enable_pin      (m_enable_pin),
        .m_data_nibble     (m_data_nibble),
        .m_hold_us         (m_hold_us),
        .m_last_step       (m_last_step)
    );

    char_lcd_pin_checker pin_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_byte_value      (s_byte_value),
        .s_register_select (s_register_select),
        .s_column          (s_column),
        .s_row             (s_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rs_pin          (m_rs_pin),
        .m_enable_pin      (m_enable_pin),
        .m_data_nibble     (m_data_nibble),
        .m_hold_us         (m_hold_us),
        .m_last_step       (m_last_step),
        .mismatch_count    (mismatch_count),
        .pins_pending      (pins_pending)
    );

    // Offer one request beat. Idle first, at the phase's rate, then raise
    // valid and hold it with the payload until the block takes the beat.
    task automatic offer_request(input logic [1:0] op, input logic [7:0] value,
                                 input logic mode, input logic [5:0] col,
                                 input logic row);
        int idle_pct;
        idle_pct = (phase == PH_SLOW_SINK)   ? 23 :
                   (phase == PH_SLOW_SOURCE) ? 58 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= op;
        s_byte_value      <= value;
        s_register_select <= mode;
        s_column          <= col;
        s_row             <= row;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: stall at the phase's rate. On entering the full-rate phase,
    // hold off once for a long stretch so the job queue fills and s_ready
    // drops while the sender keeps offering beats.
    int   stall_left = 0;
    logic stall_done = 1'b0;

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (phase == PH_FULL_RATE && !stall_done) begin
            stall_done = 1'b1;
            stall_left = LONG_STALL - 1;
            m_ready <= 1'b0;
        end else begin
            case (phase)
                PH_SLOW_SINK:   m_ready <= ($urandom_range(99) >= 58);
                PH_SLOW_SOURCE: m_ready <= ($urandom_range(99) >= 23);
                default:        m_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel and
    // drop the run once that stretch gets far longer than any legal stall.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         pick;
        logic [1:0] op;

        // Hold reset, then release it at a rising edge
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: power-up from reset levels, byte extremes in both
        // register modes, power-up after RS was left high, cursor corners
        // on both rows (including the top address 0xFF), unused fields set
        // on every operation, and the unused operation code.
        offer_request(OP_INIT,   8'h00, 1'b0, 6'd0,  1'b0);
        offer_request(OP_BYTE,   8'h00, 1'b0, 6'd0,  1'b0);
        offer_request(OP_BYTE,   8'hFF, 1'b1, 6'd63, 1'b1);
        offer_request(OP_BYTE,   8'hA5, 1'b1, 6'd0,  1'b0);
        offer_request(OP_BYTE,   8'h5A, 1'b0, 6'd21, 1'b1);
        offer_request(OP_BYTE,   8'h7E, 1'b1, 6'd42, 1'b0);
        offer_request(OP_INIT,   8'hFF, 1'b1, 6'd63, 1'b1);
        offer_request(OP_CURSOR, 8'h00, 1'b0, 6'd0,  1'b0);
        offer_request(OP_CURSOR, 8'hFF, 1'b1, 6'd63, 1'b0);
        offer_request(OP_CURSOR, 8'h55, 1'b0, 6'd0,  1'b1);
        offer_request(OP_CURSOR, 8'hAA, 1'b1, 6'd63, 1'b1);
        offer_request(OP_NONE,   8'hFF, 1'b1, 6'd63, 1'b1);
        offer_request(OP_BYTE,   8'h01, 1'b1, 6'd1,  1'b0);
        offer_request(OP_NONE,   8'h00, 1'b0, 6'd0,  1'b0);
        offer_request(OP_CURSOR, 8'h12, 1'b1, 6'd40, 1'b1);
        offer_request(OP_BYTE,   8'h80, 1'b0, 6'd32, 1'b1);
        offer_request(OP_INIT,   8'h3C, 1'b0, 6'd5,  1'b0);
        offer_request(OP_BYTE,   8'hFE, 1'b1, 6'd17, 1'b0);

        // Random: mostly byte sends and cursor sets, some power-ups, a few
        // unused codes that do not count. Advance the traffic phase every
        // REQUESTS_PER_PH counted requests.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (sent / REQUESTS_PER_PH != int'(phase))
                phase <= traffic_phase_t'(sent / REQUESTS_PER_PH);
            pick = $urandom_range(99);
            op   = (pick < 8)  ? OP_INIT :
                   (pick < 70) ? OP_BYTE :
                   (pick < 95) ? OP_CURSOR : OP_NONE;
            offer_request(op, 8'($urandom), 1'($urandom), 6'($urandom), 1'($urandom));
            if (op != OP_NONE) sent++;
        end
        s_valid <= 1'b0;

        // Drain: let the last prediction become visible, then wait for every
        // due pin state, then wait out the drain period for stray beats.
        @(posedge aclk);
        while (pins_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pins_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: char_lcd_nibble_write_sequencer_unit.f
sv/lcdseq_pkg.sv
sv/lcdseq_front.sv
sv/lcdseq_queue.sv
sv/lcdseq_back.sv
sv/char_lcd_nibble_write_sequencer_unit.sv
dv/char_lcd_pin_checker.sv
dv/char_lcd_nibble_write_sequencer_unit_tb.sv
